@@ rtl/bte_pkg.sv @@
// Shared types, codes and field layout for the breakpoint table engine.
package bte_pkg;

  localparam int REQ_W   = 3;
  localparam int STS_W   = 2;
  localparam int ADDR_W  = 64;
  localparam int WORD_W  = 64;
  localparam int RID_W   = 16;
  localparam int BYTE_W  = 8;

  // Input tdata: target_address, request_id, mem_word
  localparam int IN_ADDR_LSB  = 0;
  localparam int IN_RID_LSB   = IN_ADDR_LSB + ADDR_W;
  localparam int IN_WORD_LSB  = IN_RID_LSB + RID_W;
  localparam int IN_TDATA_W   = 144;

  // Output tdata: hit, armed, result_id, original_byte, write_address,
  // write_data, write_valid
  localparam int OB_HIT   = 0;
  localparam int OB_ARMED = 1;
  localparam int OB_ID    = 2;
  localparam int OB_BYTE  = OB_ID + RID_W;
  localparam int OB_WADDR = OB_BYTE + BYTE_W;
  localparam int OB_WDATA = OB_WADDR + ADDR_W;
  localparam int OB_WV    = OB_WDATA + WORD_W;
  localparam int OUT_TDATA_W = 160;

  localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DISABLE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ENABLE  = 3'd4;

  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_DUP     = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL    = 2'd2;
  localparam logic [STS_W-1:0] STS_MISSING = 2'd3;

  localparam logic [BYTE_W-1:0] OPC_TRAP = 8'hCC;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPD
  } bte_state_t;

  typedef struct packed {
    logic hit;
    logic free_found;
  } scan_flags_t;

  function automatic logic [WORD_W-1:0] splice(input logic [WORD_W-1:0] word,
                                               input logic [BYTE_W-1:0] low);
    splice = {word[WORD_W-1:BYTE_W], low};
  endfunction

endpackage

@@ rtl/breakpoint_table_engine_unit.sv @@
// Breakpoint table engine top level: sequencer, slot flags and result register.
//
//  channel | ports                           | word
//  --------+---------------------------------+---------------------------------------
//  in      | in_tvalid/in_tready/in_tdata/.. | tuser req_type; tdata address, id, word
//  out     | out_tvalid/out_tready/out_tdata | tuser status; tdata hit .. write_valid
//
// A request passes through accept, a scan that reads one slot per cycle through
// the single read port of the entry memory, a drain for the read latency, one update.
// The update waits while the previous result still sits unread in the output register.
// Reset is synchronous, active low; it clears used and armed flags and sets the next id
// to one. in_tready is high only while the sequencer is idle.
module breakpoint_table_engine_unit #(
  parameter int SLOT_COUNT = 64,
  parameter int IDENT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [63:0] target_address, [79:64] request_id, [143:80] mem_word
  input  logic [bte_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [2:0] req_type
  input  logic [bte_pkg::REQ_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] hit, [1] armed, [17:2] result_id, [25:18] original_byte,
  // [89:26] write_address, [153:90] write_data, [154] write_valid, [159:155] zero
  output logic [bte_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic [bte_pkg::STS_W-1:0]        out_tuser
);
  import bte_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int ENT_W = ADDR_W + IDENT_BITS + BYTE_W;

  bte_state_t state_r, state_nxt;

  logic [CNT_W-1:0]      cnt_r;
  logic [REQ_W-1:0]      req_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [RID_W-1:0]      rid_r;
  logic [WORD_W-1:0]     word_r;
  logic [SLOT_COUNT-1:0] used_r;
  logic [SLOT_COUNT-1:0] armed_r;
  logic [IDENT_BITS-1:0] next_ident_r;
  logic                  chk_r;
  logic [IDX_W-1:0]      chk_idx_r;
  logic                  chk_used_r;

  logic                  out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [STS_W-1:0]      out_tuser_r;

  logic                  in_acc;
  logic                  rd_en;
  logic                  upd_fire;
  logic                  out_free;
  logic                  last_rd;
  logic [IDX_W-1:0]      rd_idx;

  logic [ENT_W-1:0]      rd_data;
  scan_flags_t           flags;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      free_idx;
  logic [ADDR_W-1:0]     cap_addr;
  logic [IDENT_BITS-1:0] cap_ident;
  logic [BYTE_W-1:0]     cap_byte;

  // update decisions
  logic [STS_W-1:0]      r_sts;
  logic                  r_hit;
  logic                  r_arm;
  logic [RID_W-1:0]      r_id;
  logic [BYTE_W-1:0]     r_byte;
  logic [ADDR_W-1:0]     r_wa;
  logic [WORD_W-1:0]     r_wd;
  logic                  r_wv;
  logic                  mem_we_c;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_widx;
  logic [ENT_W-1:0]      mem_wdata;
  logic                  set_used;
  logic                  clr_used;
  logic                  set_arm;
  logic                  clr_arm;
  logic                  bump;
  logic [IDX_W-1:0]      tgt_idx;
  logic                  m_armed;
  logic [31:0]           cap_id_ext;
  logic [31:0]           nxt_id_ext;

  assign rd_idx   = cnt_r[IDX_W-1:0];
  assign last_rd  = (cnt_r == CNT_W'(SLOT_COUNT - 1));
  assign out_free = !out_tvalid_r || out_tready;
  assign in_acc   = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_SCAN;
      ST_SCAN:  if (last_rd) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_UPD;
      ST_UPD:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    upd_fire  = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_SCAN:  rd_en     = 1'b1;
      ST_DRAIN: ;
      ST_UPD:   upd_fire  = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      chk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chk_r   <= rd_en;
      if (in_acc) begin
        cnt_r <= '0;
      end else if (rd_en) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_tuser;
      addr_r <= in_tdata[IN_ADDR_LSB +: ADDR_W];
      rid_r  <= in_tdata[IN_RID_LSB +: RID_W];
      word_r <= in_tdata[IN_WORD_LSB +: WORD_W];
    end
    chk_idx_r  <= rd_idx;
    chk_used_r <= used_r[rd_idx];
  end

  bte_slot_mem #(
    .DEPTH  (SLOT_COUNT),
    .IDX_W  (IDX_W),
    .DATA_W (ENT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_widx),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  bte_scan #(
    .IDX_W      (IDX_W),
    .IDENT_BITS (IDENT_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (in_acc),
    .chk       (chk_r),
    .chk_idx   (chk_idx_r),
    .chk_used  (chk_used_r),
    .is_remove (req_r == REQ_REMOVE),
    .key_addr  (addr_r),
    .key_rid   (rid_r),
    .ent_addr  (rd_data[ENT_W-1 -: ADDR_W]),
    .ent_ident (rd_data[BYTE_W +: IDENT_BITS]),
    .ent_byte  (rd_data[BYTE_W-1:0]),
    .flags     (flags),
    .hit_idx   (hit_idx),
    .free_idx  (free_idx),
    .cap_addr  (cap_addr),
    .cap_ident (cap_ident),
    .cap_byte  (cap_byte)
  );

  assign m_armed    = armed_r[hit_idx];
  assign cap_id_ext = 32'(cap_ident);
  assign nxt_id_ext = 32'(next_ident_r);

  always_comb begin
    r_sts     = STS_MISSING;
    r_hit     = 1'b0;
    r_arm     = 1'b0;
    r_id      = '0;
    r_byte    = '0;
    r_wa      = '0;
    r_wd      = '0;
    r_wv      = 1'b0;
    mem_we_c  = 1'b0;
    mem_widx  = hit_idx;
    mem_wdata = {cap_addr, cap_ident, cap_byte};
    set_used  = 1'b0;
    clr_used  = 1'b0;
    set_arm   = 1'b0;
    clr_arm   = 1'b0;
    bump      = 1'b0;
    tgt_idx   = hit_idx;
    case (req_r)
      REQ_ADD: begin
        if (flags.hit) begin
          r_sts  = STS_DUP;
          r_hit  = 1'b1;
          r_arm  = m_armed;
          r_id   = cap_id_ext[RID_W-1:0];
          r_byte = cap_byte;
        end else if (flags.free_found) begin
          r_sts     = STS_OK;
          r_arm     = 1'b1;
          r_id      = nxt_id_ext[RID_W-1:0];
          r_byte    = word_r[BYTE_W-1:0];
          r_wv      = 1'b1;
          r_wa      = addr_r;
          r_wd      = splice(word_r, OPC_TRAP);
          mem_we_c  = 1'b1;
          mem_widx  = free_idx;
          mem_wdata = {addr_r, next_ident_r, word_r[BYTE_W-1:0]};
          set_used  = 1'b1;
          set_arm   = 1'b1;
          tgt_idx   = free_idx;
          bump      = 1'b1;
        end else begin
          r_sts = STS_FULL;
        end
      end
      REQ_REMOVE: begin
        if (flags.hit) begin
          r_sts    = STS_OK;
          r_hit    = 1'b1;
          r_id     = cap_id_ext[RID_W-1:0];
          r_byte   = cap_byte;
          clr_used = 1'b1;
          if (m_armed) begin
            r_wv    = 1'b1;
            r_wa    = cap_addr;
            r_wd    = splice(word_r, cap_byte);
            clr_arm = 1'b1;
          end
        end
      end
      REQ_QUERY: begin
        if (flags.hit) begin
          r_sts  = STS_OK;
          r_hit  = 1'b1;
          r_arm  = m_armed;
          r_id   = cap_id_ext[RID_W-1:0];
          r_byte = cap_byte;
        end
      end
      REQ_DISABLE: begin
        if (flags.hit) begin
          r_sts  = STS_OK;
          r_hit  = 1'b1;
          r_id   = cap_id_ext[RID_W-1:0];
          r_byte = cap_byte;
          if (m_armed) begin
            r_wv    = 1'b1;
            r_wa    = addr_r;
            r_wd    = splice(word_r, cap_byte);
            clr_arm = 1'b1;
          end
        end
      end
      REQ_ENABLE: begin
        if (flags.hit) begin
          r_sts = STS_OK;
          r_hit = 1'b1;
          r_arm = 1'b1;
          r_id  = cap_id_ext[RID_W-1:0];
          if (m_armed) begin
            r_byte = cap_byte;
          end else begin
            // resave the opcode byte and replant the trap
            r_byte    = word_r[BYTE_W-1:0];
            r_wv      = 1'b1;
            r_wa      = addr_r;
            r_wd      = splice(word_r, OPC_TRAP);
            mem_we_c  = 1'b1;
            mem_wdata = {cap_addr, cap_ident, word_r[BYTE_W-1:0]};
            set_arm   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign mem_we = mem_we_c && upd_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      armed_r      <= '0;
      next_ident_r <= IDENT_BITS'(1);
    end else if (upd_fire) begin
      if (set_used) used_r[tgt_idx]  <= 1'b1;
      if (clr_used) used_r[tgt_idx]  <= 1'b0;
      if (set_arm)  armed_r[tgt_idx] <= 1'b1;
      if (clr_arm)  armed_r[tgt_idx] <= 1'b0;
      if (bump)     next_ident_r     <= next_ident_r + IDENT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (upd_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_tuser_r <= r_sts;
      out_tdata_r <= {(OUT_TDATA_W - OB_WV - 1)'(0), r_wv, r_wd, r_wa, r_byte, r_id,
                      r_arm, r_hit};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTH
  a_mem_we_upd: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == ST_UPD)
    else $error("entry memory written outside update");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> cnt_r < CNT_W'(SLOT_COUNT))
    else $error("scan index beyond table");

  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OB_WV] |-> out_tuser == STS_OK)
    else $error("memory write reported with non-ok status");

  a_ident_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_UPD |=> $stable(next_ident_r))
    else $error("next id moved outside update");
`endif

endmodule

@@ rtl/bte_slot_mem.sv @@
// Slot entry memory: one write port, one registered read port.
module bte_slot_mem #(
  parameter int DEPTH  = 64,
  parameter int IDX_W  = 6,
  parameter int DATA_W = 88
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [IDX_W-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bte_scan.sv @@
// Shared slot comparator: tracks the first matching slot and the first free slot.
module bte_scan #(
  parameter int IDX_W      = 6,
  parameter int IDENT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clr,
  input  logic                      chk,
  input  logic [IDX_W-1:0]          chk_idx,
  input  logic                      chk_used,
  input  logic                      is_remove,
  input  logic [bte_pkg::ADDR_W-1:0] key_addr,
  input  logic [bte_pkg::RID_W-1:0]  key_rid,
  input  logic [bte_pkg::ADDR_W-1:0] ent_addr,
  input  logic [IDENT_BITS-1:0]     ent_ident,
  input  logic [bte_pkg::BYTE_W-1:0] ent_byte,
  output bte_pkg::scan_flags_t      flags,
  output logic [IDX_W-1:0]          hit_idx,
  output logic [IDX_W-1:0]          free_idx,
  output logic [bte_pkg::ADDR_W-1:0] cap_addr,
  output logic [IDENT_BITS-1:0]     cap_ident,
  output logic [bte_pkg::BYTE_W-1:0] cap_byte
);
  import bte_pkg::*;

  scan_flags_t       flags_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic [ADDR_W-1:0] cap_addr_r;
  logic [IDENT_BITS-1:0] cap_ident_r;
  logic [BYTE_W-1:0] cap_byte_r;

  logic [ADDR_W-1:0] lhs;
  logic [ADDR_W-1:0] rhs;
  logic              eq;

  // one 64-bit comparator serves both the address and the id lookup
  always_comb begin
    lhs = is_remove ? ADDR_W'(ent_ident) : ent_addr;
    rhs = is_remove ? ADDR_W'(key_rid) : key_addr;
    eq  = (lhs == rhs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (clr) begin
      flags_r <= '0;
    end else if (chk) begin
      if (chk_used && eq && !flags_r.hit) begin
        flags_r.hit <= 1'b1;
      end
      if (!chk_used && !flags_r.free_found) begin
        flags_r.free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chk && chk_used && eq && !flags_r.hit && !clr) begin
      hit_idx_r   <= chk_idx;
      cap_addr_r  <= ent_addr;
      cap_ident_r <= ent_ident;
      cap_byte_r  <= ent_byte;
    end
    if (chk && !chk_used && !flags_r.free_found && !clr) begin
      free_idx_r <= chk_idx;
    end
  end

  assign flags     = flags_r;
  assign hit_idx   = hit_idx_r;
  assign free_idx  = free_idx_r;
  assign cap_addr  = cap_addr_r;
  assign cap_ident = cap_ident_r;
  assign cap_byte  = cap_byte_r;

endmodule

@@ tb/breakpoint_table_engine_unit_tb.sv @@
// Self-checking testbench for the breakpoint table engine: stream driver, monitor, predictor.
`timescale 1ns / 100ps

module breakpoint_table_engine_unit_tb;
  import bte_pkg::*;

  localparam int SLOTS = 64;
  localparam int POOL_SIZE = 96;
  localparam int RANDOM_ITEMS = 1350;
  localparam logic [REQ_W-1:0] REQ_RSVD_LO  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD_MID = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_HI  = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]  op;
    logic [ADDR_W-1:0] addr;
    logic [RID_W-1:0]  rid;
    logic [WORD_W-1:0] word;
    logic              drain_first;
  } bp_request_t;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic              hit;
    logic              armed;
    logic [RID_W-1:0]  ident;
    logic [BYTE_W-1:0] obyte;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              wv;
  } bp_result_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic [REQ_W-1:0]        in_tuser = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic [STS_W-1:0]        out_tuser;

  breakpoint_table_engine_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predicted table contents
  logic              bp_used  [SLOTS];
  logic              bp_armed [SLOTS];
  logic [ADDR_W-1:0] bp_addr  [SLOTS];
  logic [BYTE_W-1:0] bp_byte  [SLOTS];
  logic [RID_W-1:0]  bp_ident [SLOTS];
  logic [RID_W-1:0]  bp_next_ident = 16'd1;

  bp_request_t request_fifo[$];
  bp_result_t  pending_results[$];
  bp_request_t cur_req;
  bp_result_t  seen_res;
  bp_result_t  want_res;

  // Stimulus-side view of which addresses and ids are live
  logic [ADDR_W-1:0] live_addr[$];
  logic [RID_W-1:0]  live_id[$];
  logic [RID_W-1:0]  gen_next_id = 16'd1;
  logic [ADDR_W-1:0] addr_pool[POOL_SIZE];

  bit req_taken = 1'b0;
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int writes_seen = 0;
  int op_seen[8];
  int status_seen[4];
  bit calm;

  assign calm = (words_in >= 600) && (words_in < 800);

  function automatic int find_addr(input logic [ADDR_W-1:0] a);
    find_addr = -1;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (bp_used[k] && bp_addr[k] == a) find_addr = k;
    end
  endfunction

  function automatic bp_result_t apply_request(input bp_request_t r);
    bp_result_t res;
    int s;
    res = '0;
    res.status = STS_MISSING;
    s = -1;
    case (r.op)
      REQ_ADD: begin
        s = find_addr(r.addr);
        if (s >= 0) begin
          res.status = STS_DUP;
          res.hit = 1'b1;
        end else begin
          for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!bp_used[k]) s = k;
          end
          if (s < 0) begin
            res.status = STS_FULL;
          end else begin
            bp_used[s] = 1'b1;
            bp_addr[s] = r.addr;
            bp_ident[s] = bp_next_ident;
            bp_next_ident = bp_next_ident + 16'd1;
            bp_byte[s] = r.word[BYTE_W-1:0];
            bp_armed[s] = 1'b1;
            res.wv = 1'b1;
            res.waddr = r.addr;
            res.wdata = {r.word[WORD_W-1:BYTE_W], OPC_TRAP};
            res.status = STS_OK;
          end
        end
      end
      REQ_REMOVE: begin
        for (int k = SLOTS - 1; k >= 0; k--) begin
          if (bp_used[k] && bp_ident[k] == r.rid) s = k;
        end
        if (s >= 0) begin
          res.hit = 1'b1;
          res.status = STS_OK;
          if (bp_armed[s]) begin
            res.wv = 1'b1;
            res.waddr = bp_addr[s];
            res.wdata = {r.word[WORD_W-1:BYTE_W], bp_byte[s]};
            bp_armed[s] = 1'b0;
          end
          bp_used[s] = 1'b0;
        end
      end
      REQ_QUERY, REQ_DISABLE, REQ_ENABLE: begin
        s = find_addr(r.addr);
        if (s >= 0) begin
          res.hit = 1'b1;
          res.status = STS_OK;
          if (r.op == REQ_DISABLE && bp_armed[s]) begin
            res.wv = 1'b1;
            res.waddr = r.addr;
            res.wdata = {r.word[WORD_W-1:BYTE_W], bp_byte[s]};
            bp_armed[s] = 1'b0;
          end else if (r.op == REQ_ENABLE && !bp_armed[s]) begin
            bp_byte[s] = r.word[BYTE_W-1:0];
            res.wv = 1'b1;
            res.waddr = r.addr;
            res.wdata = {r.word[WORD_W-1:BYTE_W], OPC_TRAP};
            bp_armed[s] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (s >= 0) begin
      res.armed = bp_armed[s];
      res.ident = bp_ident[s];
      res.obyte = bp_byte[s];
    end
    apply_request = res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < 40) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h want %h", words_out, name, got, want));
  endtask

  // Queue a request and keep the stimulus view of live entries current
  task automatic queue_req(input logic [REQ_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [RID_W-1:0] rid, input logic [WORD_W-1:0] word,
                           input bit drain);
    bp_request_t r;
    int pos;
    r.op = op;
    r.addr = addr;
    r.rid = rid;
    r.word = word;
    r.drain_first = drain;
    request_fifo.push_back(r);
    pos = -1;
    if (op == REQ_ADD) begin
      foreach (live_addr[i]) if (live_addr[i] == addr) pos = i;
      if (pos < 0 && live_addr.size() < SLOTS) begin
        live_addr.push_back(addr);
        live_id.push_back(gen_next_id);
        gen_next_id = gen_next_id + 16'd1;
      end
    end else if (op == REQ_REMOVE) begin
      foreach (live_id[i]) if (live_id[i] == rid && pos < 0) pos = i;
      if (pos >= 0) begin
        live_addr.delete(pos);
        live_id.delete(pos);
      end
    end
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr(input int live_pct);
    int r;
    r = $urandom_range(99);
    if (live_addr.size() > 0 && r < live_pct)
      pick_addr = live_addr[$urandom_range(live_addr.size() - 1)];
    else if (r < 90)
      pick_addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
    else
      pick_addr = {$urandom, $urandom};
  endfunction

  // Sender: present the next word at the falling edge, hold it until taken
  always @(negedge clk) begin
    if (rst_n && (req_taken || !in_tvalid)) begin
      req_taken = 1'b0;
      if (request_fifo.size() > 0 && (calm || $urandom_range(99) >= 20) &&
          !(request_fifo[0].drain_first && pending_results.size() > 0)) begin
        cur_req = request_fifo.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {cur_req.word, cur_req.rid, cur_req.addr};
        in_tuser <= cur_req.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(apply_request(cur_req));
        op_seen[cur_req.op]++;
        req_taken = 1'b1;
        words_in++;
      end
      if (out_tvalid && out_tready) begin
        seen_res.status = out_tuser;
        seen_res.hit = out_tdata[OB_HIT];
        seen_res.armed = out_tdata[OB_ARMED];
        seen_res.ident = out_tdata[OB_ID +: RID_W];
        seen_res.obyte = out_tdata[OB_BYTE +: BYTE_W];
        seen_res.waddr = out_tdata[OB_WADDR +: ADDR_W];
        seen_res.wdata = out_tdata[OB_WDATA +: WORD_W];
        seen_res.wv = out_tdata[OB_WV];
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request pending", words_out));
        end else begin
          want_res = pending_results.pop_front();
          compare_field("status", 64'(seen_res.status), 64'(want_res.status));
          compare_field("hit", 64'(seen_res.hit), 64'(want_res.hit));
          compare_field("armed", 64'(seen_res.armed), 64'(want_res.armed));
          compare_field("result_id", 64'(seen_res.ident), 64'(want_res.ident));
          compare_field("original_byte", 64'(seen_res.obyte), 64'(want_res.obyte));
          compare_field("write_address", seen_res.waddr, want_res.waddr);
          compare_field("write_data", seen_res.wdata, want_res.wdata);
          compare_field("write_valid", 64'(seen_res.wv), 64'(want_res.wv));
          status_seen[want_res.status]++;
          if (want_res.wv) writes_seen++;
        end
        words_out++;
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("FAIL breakpoint_table_engine_unit");
    $finish;
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] hi_addr;
    logic [REQ_W-1:0] op;
    logic [RID_W-1:0] rid;
    int pick;
    int add_cut;
    bit fill;

    for (int k = 0; k < SLOTS; k++) begin
      bp_used[k] = 1'b0;
      bp_armed[k] = 1'b0;
      bp_addr[k] = '0;
      bp_byte[k] = '0;
      bp_ident[k] = '0;
    end
    foreach (op_seen[i]) op_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) addr_pool[k] = {$urandom, $urandom};
    hi_addr = '1;

    // Directed: extremes, every request kind, arm/disarm corners
    queue_req(REQ_QUERY, '0, '0, '0, 1'b0);
    queue_req(REQ_ADD, '0, 16'hFFFF, '1, 1'b0);
    queue_req(REQ_ADD, hi_addr, '0, '0, 1'b0);
    queue_req(REQ_ADD, '0, '0, 64'h0123_4567_89AB_CDEF, 1'b0);
    queue_req(REQ_QUERY, hi_addr, '1, '1, 1'b0);
    queue_req(REQ_DISABLE, '0, '0, 64'hFEDC_BA98_7654_32CC, 1'b0);
    queue_req(REQ_DISABLE, '0, '0, '1, 1'b0);
    queue_req(REQ_QUERY, '0, '0, '0, 1'b0);
    queue_req(REQ_ENABLE, '0, '0, 64'h5555_AAAA_5555_AA5A, 1'b0);
    queue_req(REQ_ENABLE, '0, '0, '0, 1'b0);
    queue_req(REQ_REMOVE, '1, 16'd2, '1, 1'b0);
    queue_req(REQ_REMOVE, '0, 16'd2, '0, 1'b0);
    queue_req(REQ_REMOVE, '0, 16'hFFFF, '1, 1'b0);
    queue_req(REQ_REMOVE, '0, 16'd0, '1, 1'b0);
    queue_req(REQ_DISABLE, hi_addr, '0, '0, 1'b0);
    queue_req(REQ_ENABLE, hi_addr, '0, '1, 1'b0);
    queue_req(REQ_DISABLE, '0, '0, 64'h8000_0000_0000_0001, 1'b0);
    queue_req(REQ_REMOVE, '0, 16'd1, 64'h7FFF_FFFF_FFFF_FF00, 1'b0);
    queue_req(REQ_QUERY, '0, '0, '0, 1'b0);
    queue_req(REQ_RSVD_LO, '1, '1, '1, 1'b0);
    queue_req(REQ_RSVD_MID, '1, '1, '1, 1'b0);
    queue_req(REQ_RSVD_HI, '0, '0, '0, 1'b0);
    queue_req(REQ_ADD, hi_addr, 16'h8000, 64'h0000_0000_0000_0080, 1'b1);

    // Random: alternate fill and drain phases so the table runs full and empties again
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      fill = ((n / 300) % 2) == 0;
      add_cut = fill ? 45 : 15;
      pick = $urandom_range(99);
      rid = RID_W'($urandom);
      if (pick < add_cut) begin
        op = REQ_ADD;
      end else if (pick < 55) begin
        op = REQ_REMOVE;
        if (live_id.size() > 0 && $urandom_range(99) < 80)
          rid = live_id[$urandom_range(live_id.size() - 1)];
      end else if (pick < 68) begin
        op = REQ_QUERY;
      end else if (pick < 81) begin
        op = REQ_DISABLE;
      end else if (pick < 94) begin
        op = REQ_ENABLE;
      end else begin
        op = REQ_W'($urandom_range(REQ_RSVD_HI, REQ_RSVD_LO));
      end
      queue_req(op, (op == REQ_REMOVE) ? {$urandom, $urandom} :
                    pick_addr((op == REQ_ADD) ? 15 : 75),
                rid, {$urandom, $urandom}, (n == 400) || (n == 950));
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_fifo.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);

    $display("Covered %0d requests: add %0d, remove %0d, query %0d, disable %0d, enable %0d",
             words_in, op_seen[REQ_ADD], op_seen[REQ_REMOVE], op_seen[REQ_QUERY],
             op_seen[REQ_DISABLE], op_seen[REQ_ENABLE]);
    $display("Answers: ok %0d, duplicate %0d, full %0d, not found %0d; memory writes %0d",
             status_seen[STS_OK], status_seen[STS_DUP], status_seen[STS_FULL],
             status_seen[STS_MISSING], writes_seen);
    if (errors == 0) begin
      $display("PASS breakpoint_table_engine_unit");
    end else begin
      $display("FAIL breakpoint_table_engine_unit");
    end
    $finish;
  end

endmodule
